/* src/wzcr_pkg.sv */
// ----------------------------------------------------------------------------
// wzcr_pkg
// Shared types and constants for the windowed zero crossing rate block.
// ----------------------------------------------------------------------------
`default_nettype none

package wzcr_pkg;

    localparam int WINDOW_MAX  = 256;
    localparam int SAMPLE_BITS = 16;
    localparam int ADDR_W      = $clog2(WINDOW_MAX);
    localparam int FILL_W      = $clog2(WINDOW_MAX + 1);
    localparam int CROSS_W     = $clog2(WINDOW_MAX);
    localparam int FRAC_W      = 16;
    localparam int RATE_W      = FRAC_W + 1;
    localparam int CNT_W       = 32;
    localparam int CFG_W       = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int DIV_CNT_W   = $clog2(FRAC_W + 1);
    localparam int OUT_BITS    = RATE_W + 3 + 3 * CNT_W;
    localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;
    localparam int IN_DATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 2'd3;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    localparam logic [FILL_W-1:0] WINDOW_RESET  = FILL_W'(64);
    localparam logic [FILL_W-1:0] MIN_RESET     = FILL_W'(2);
    localparam logic [RATE_W-1:0] HIGH_TH_RESET = RATE_W'(32768);
    localparam logic [RATE_W-1:0] LOW_TH_RESET  = RATE_W'(6554);
    localparam logic [FILL_W-1:0] FILL_FLOOR    = FILL_W'(2);
    localparam logic [FILL_W-1:0] FILL_CEIL     = FILL_W'(WINDOW_MAX);
    localparam logic [CNT_W-1:0]  CNT_FULL      = {CNT_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_OLD,
        ST_RD_NEXT,
        ST_UPDATE,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              wr_data;
    } hist_req_t;

    typedef struct packed {
        logic               start;
        logic [CROSS_W-1:0] num;
        logic [CROSS_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [RATE_W-1:0] quo;
    } div_rsp_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_FULL) ? v : v + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

/* src/wzcr_hist.sv */
// ----------------------------------------------------------------------------
// wzcr_hist
// Sign history ring storage: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wzcr_hist (
    input  wire logic                 aclk,
    input  wire wzcr_pkg::hist_req_t  req,
    output logic                      rd_data
);
    import wzcr_pkg::*;

    logic mem [WINDOW_MAX];
    logic rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* src/wzcr_div.sv */
// ----------------------------------------------------------------------------
// wzcr_div
// Serial restoring divider: (num << 16) / den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wzcr_div (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire wzcr_pkg::div_req_t  req,
    output wzcr_pkg::div_rsp_t       rsp
);
    import wzcr_pkg::*;

    logic                 busy_reg,  busy_next;
    logic                 done_reg,  done_next;
    logic [DIV_CNT_W-1:0] cnt_reg,   cnt_next;
    logic [CROSS_W-1:0]   rem_reg,   rem_next;
    logic [CROSS_W-1:0]   den_reg,   den_next;
    logic [RATE_W-1:0]    quo_reg,   quo_next;
    logic [CROSS_W:0]     trial;
    logic                 fits;

    assign trial = {rem_reg, 1'b0};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (req.start) begin
            den_next = req.den;
            if (req.num == req.den) begin
                quo_next  = RATE_W'(1) << FRAC_W;
                done_next = 1'b1;
                busy_next = 1'b0;
            end else begin
                rem_next  = req.num;
                quo_next  = '0;
                cnt_next  = DIV_CNT_W'(FRAC_W);
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            rem_next = fits ? CROSS_W'(trial - {1'b0, den_reg}) : trial[CROSS_W-1:0];
            quo_next = {quo_reg[RATE_W-2:0], fits};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

`default_nettype wire

/* src/windowed_zero_crossing_rate_top.sv */
// ----------------------------------------------------------------------------
// windowed_zero_crossing_rate_top
// Sliding-window zero crossing rate with threshold events and counters.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one beat per sample: s_tdata holds the signed sample,
//   s_tuser the command (record or clear). m_ channel returns one beat per
//   input beat with the rate, ready flag, both event flags and the three
//   saturating counters.
//   A record beat walks the sequencer: two reads of the sign ring memory,
//   an update step, then the serial divider (16 quotient bits, one per
//   cycle; it answers directly when crossings equal fill minus one), then
//   the finish state. A clear beat goes straight to the finish state, and a
//   sample without a rate yet skips the divider. s_tready is high only in
//   the idle state, so the block takes no new beat until the last one has
//   finished; the serial divider and the single ring read port set the pace.
//   The result waits in an output register, so the next beat is taken while
//   the receiver stalls; a finished result holds the sequencer until the
//   output register is free.
//   Reset loads the default registers and empties the ring, counters and
//   event history. Any register write empties the ring only.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_zero_crossing_rate_top (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [wzcr_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  wire logic [wzcr_pkg::CFG_W-1:0]            cfg_data,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [wzcr_pkg::IN_DATA_W-1:0]        s_tdata,   // sample
    input  wire logic                                  s_tuser,   // command
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // rate, rate_ready, hi_flag, lo_flag, hi_count,
    // lo_count, record_count, zero pad
    output logic [wzcr_pkg::OUT_DATA_W-1:0]            m_tdata
);
    import wzcr_pkg::*;

    state_t state_reg, state_next;

    logic [FILL_W-1:0]  wl_reg, ms_reg;
    logic [RATE_W-1:0]  hth_reg, lth_reg;
    logic [ADDR_W-1:0]  wp_reg, wp_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [CROSS_W-1:0] cross_reg, cross_next;
    logic               prev_reg, prev_next;
    logic               neg_reg, neg_next;
    logic               cmd_reg, cmd_next;
    logic               old_reg, old_next;
    logic               rdy_reg, rdy_next;
    logic               hi_reg, hi_next;
    logic               lo_reg, lo_next;
    logic [CNT_W-1:0]   hcnt_reg, hcnt_next;
    logic [CNT_W-1:0]   lcnt_reg, lcnt_next;
    logic [CNT_W-1:0]   rcnt_reg, rcnt_next;
    logic               mvalid_reg, mvalid_next;
    logic [OUT_DATA_W-1:0] mdata_reg, mdata_next;

    logic [FILL_W-1:0]  w_eff, ms_eff, wp_plus1, fill_inc;
    logic [ADDR_W-1:0]  wp_wrap;
    logic               accept, out_free, full, drop, add, h, l, hev, lev;
    logic [CROSS_W:0]   cross_sum;
    logic [RATE_W-1:0]  rate;

    hist_req_t hreq;
    logic      hist_rd;
    div_req_t  dreq;
    div_rsp_t  drsp;

    wzcr_hist u_hist (
        .aclk    (aclk),
        .req     (hreq),
        .rd_data (hist_rd)
    );

    wzcr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    assign w_eff  = (wl_reg < FILL_FLOOR) ? FILL_FLOOR :
                    (wl_reg > FILL_CEIL)  ? FILL_CEIL  : wl_reg;
    assign ms_eff = (ms_reg < FILL_FLOOR) ? FILL_FLOOR : ms_reg;

    assign wp_plus1 = {1'b0, wp_reg} + FILL_W'(1);
    assign wp_wrap  = (wp_plus1 == w_eff) ? '0 : wp_plus1[ADDR_W-1:0];
    assign full     = (fill_reg == w_eff);
    assign fill_inc = full ? fill_reg : fill_reg + FILL_W'(1);
    assign drop     = full && (old_reg != hist_rd);
    assign add      = (fill_reg != '0) && (prev_reg != neg_reg);
    assign cross_sum = {1'b0, cross_reg} - (CROSS_W+1)'(drop) + (CROSS_W+1)'(add);

    assign accept   = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;

    assign rate = rdy_reg ? drsp.quo : '0;
    assign h    = rate > hth_reg;
    assign l    = rate < lth_reg;
    assign hev  = rdy_reg && h && !hi_reg;
    assign lev  = rdy_reg && l && !lo_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_tuser == CMD_CLEAR) ? ST_FINISH : ST_RD_OLD;
                end
            end
            ST_RD_OLD:  state_next = ST_RD_NEXT;
            ST_RD_NEXT: state_next = ST_UPDATE;
            ST_UPDATE:  state_next = (fill_inc >= ms_eff) ? ST_DIVIDE : ST_FINISH;
            ST_DIVIDE: begin
                if (drsp.done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready     = 1'b0;
        hreq.rd_en   = 1'b0;
        hreq.rd_addr = wp_reg;
        hreq.wr_en   = 1'b0;
        hreq.wr_addr = wp_reg;
        hreq.wr_data = neg_reg;
        dreq.start   = 1'b0;
        dreq.num     = cross_sum[CROSS_W-1:0];
        dreq.den     = CROSS_W'(fill_inc - FILL_W'(1));
        unique case (state_reg)
            ST_IDLE:    s_tready = 1'b1;
            ST_RD_OLD:  hreq.rd_en = 1'b1;
            ST_RD_NEXT: begin
                hreq.rd_en   = 1'b1;
                hreq.rd_addr = wp_wrap;
            end
            ST_UPDATE: begin
                hreq.wr_en = 1'b1;
                dreq.start = (fill_inc >= ms_eff);
            end
            ST_DIVIDE, ST_FINISH: ;
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        wp_next     = wp_reg;
        fill_next   = fill_reg;
        cross_next  = cross_reg;
        prev_next   = prev_reg;
        neg_next    = neg_reg;
        cmd_next    = cmd_reg;
        old_next    = old_reg;
        rdy_next    = rdy_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        hcnt_next   = hcnt_reg;
        lcnt_next   = lcnt_reg;
        rcnt_next   = rcnt_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            wp_next    = '0;
            fill_next  = '0;
            cross_next = '0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd_next = s_tuser;
                    neg_next = s_tdata[SAMPLE_BITS-1];
                    rdy_next = 1'b0;
                    if (s_tuser == CMD_CLEAR) begin
                        wp_next    = '0;
                        fill_next  = '0;
                        cross_next = '0;
                        hi_next    = 1'b0;
                        lo_next    = 1'b0;
                        hcnt_next  = '0;
                        lcnt_next  = '0;
                        rcnt_next  = '0;
                    end
                end
            end
            ST_RD_OLD: ;
            ST_RD_NEXT: old_next = hist_rd;
            ST_UPDATE: begin
                cross_next = cross_sum[CROSS_W-1:0];
                fill_next  = fill_inc;
                wp_next    = wp_wrap;
                prev_next  = neg_reg;
                rdy_next   = (fill_inc >= ms_eff);
            end
            ST_DIVIDE: ;
            ST_FINISH: begin
                if (out_free) begin
                    if (rdy_reg) begin
                        hi_next = h;
                        lo_next = l;
                    end
                    if (hev) begin
                        hcnt_next = sat_inc(hcnt_reg);
                    end
                    if (lev) begin
                        lcnt_next = sat_inc(lcnt_reg);
                    end
                    if (cmd_reg == CMD_RECORD) begin
                        rcnt_next = sat_inc(rcnt_reg);
                    end
                    mvalid_next = 1'b1;
                    mdata_next  = OUT_DATA_W'({rcnt_next, lcnt_next, hcnt_next,
                                               lev, hev, rdy_reg, rate});
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            wl_reg     <= WINDOW_RESET;
            ms_reg     <= MIN_RESET;
            hth_reg    <= HIGH_TH_RESET;
            lth_reg    <= LOW_TH_RESET;
            wp_reg     <= '0;
            fill_reg   <= '0;
            cross_reg  <= '0;
            prev_reg   <= 1'b0;
            cmd_reg    <= CMD_RECORD;
            rdy_reg    <= 1'b0;
            hi_reg     <= 1'b0;
            lo_reg     <= 1'b0;
            hcnt_reg   <= '0;
            lcnt_reg   <= '0;
            rcnt_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            wp_reg     <= wp_next;
            fill_reg   <= fill_next;
            cross_reg  <= cross_next;
            prev_reg   <= prev_next;
            cmd_reg    <= cmd_next;
            rdy_reg    <= rdy_next;
            hi_reg     <= hi_next;
            lo_reg     <= lo_next;
            hcnt_reg   <= hcnt_next;
            lcnt_reg   <= lcnt_next;
            rcnt_reg   <= rcnt_next;
            mvalid_reg <= mvalid_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_WINDOW_LENGTH:  wl_reg  <= cfg_data[FILL_W-1:0];
                    CFG_MIN_SAMPLES:    ms_reg  <= cfg_data[FILL_W-1:0];
                    CFG_HIGH_THRESHOLD: hth_reg <= cfg_data[RATE_W-1:0];
                    CFG_LOW_THRESHOLD:  lth_reg <= cfg_data[RATE_W-1:0];
                    default: ;
                endcase
            end
        end
        neg_reg   <= neg_next;
        old_reg   <= old_next;
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

endmodule

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the windowed zero crossing rate block. A scoreboard
// class tracks the sign ring, the event edge flags and the counters, and
// predicts every output beat. Directed beats cover sign extremes, both event
// kinds and the clear command. Random runs of constant, alternating and
// sparse-flip sign patterns follow under several register settings, including
// clamped window and minimum fill values. Both stream sides idle at random, and
// the receiver holds off once long enough to stall the input side.
// ----------------------------------------------------------------------------

module testbench;

    import wzcr_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AT       = 150;
    localparam int DRAIN_CYCLES  = 40;
    localparam int READY_BIT     = RATE_W;
    localparam int HEV_BIT       = RATE_W + 1;
    localparam int LEV_BIT       = RATE_W + 2;
    localparam int HCNT_LSB      = RATE_W + 3;
    localparam int LCNT_LSB      = HCNT_LSB + CNT_W;
    localparam int RCNT_LSB      = LCNT_LSB + CNT_W;

    typedef struct {
        logic [RATE_W-1:0] rate;
        logic              ready;
        logic              hi_ev;
        logic              lo_ev;
        logic [CNT_W-1:0]  hi_cnt;
        logic [CNT_W-1:0]  lo_cnt;
        logic [CNT_W-1:0]  rec_cnt;
    } rate_beat_t;

    class crossing_rate_scoreboard;
        bit               sign_ring [WINDOW_MAX];
        int unsigned      wr_pos;
        int unsigned      fill;
        bit               above_hi;
        bit               below_lo;
        logic [CNT_W-1:0] hi_total;
        logic [CNT_W-1:0] lo_total;
        logic [CNT_W-1:0] rec_total;
        logic [8:0]       win_len;
        logic [8:0]       min_fill;
        logic [16:0]      hi_th;
        logic [16:0]      lo_th;
        rate_beat_t       pending_rates [$];
        int unsigned      errors;
        int unsigned      checked;
        int unsigned      ready_beats;
        int unsigned      hi_events;
        int unsigned      lo_events;

        function new();
            win_len  = 9'(WINDOW_RESET);
            min_fill = 9'(MIN_RESET);
            hi_th    = HIGH_TH_RESET;
            lo_th    = LOW_TH_RESET;
            empty_ring();
            above_hi  = 1'b0;
            below_lo  = 1'b0;
            hi_total  = '0;
            lo_total  = '0;
            rec_total = '0;
        endfunction

        function void empty_ring();
            foreach (sign_ring[k]) sign_ring[k] = 1'b0;
            wr_pos = 0;
            fill   = 0;
        endfunction

        function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
            return (v == CNT_FULL) ? v : v + 1'b1;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_WINDOW_LENGTH:  win_len  = val[8:0];
                CFG_MIN_SAMPLES:    min_fill = val[8:0];
                CFG_HIGH_THRESHOLD: hi_th    = val[16:0];
                CFG_LOW_THRESHOLD:  lo_th    = val[16:0];
                default: ;
            endcase
            empty_ring();
        endfunction

        function int unsigned pending();
            return pending_rates.size();
        endfunction

        // predict the output beat caused by one accepted input beat
        function void record_beat(logic cmd, logic [IN_DATA_W-1:0] smp);
            rate_beat_t  r;
            int unsigned w;
            int unsigned ms;
            int unsigned start;
            int unsigned crossings;
            int unsigned i;
            int unsigned q;
            bit          hi;
            bit          lo;
            r = '{default: 0};
            if (cmd == CMD_CLEAR) begin
                empty_ring();
                above_hi  = 1'b0;
                below_lo  = 1'b0;
                hi_total  = '0;
                lo_total  = '0;
                rec_total = '0;
            end else begin
                w  = (win_len < 2) ? 2 : (win_len > WINDOW_MAX) ? WINDOW_MAX : win_len;
                ms = (min_fill < 2) ? 2 : min_fill;
                if (wr_pos >= w) wr_pos = 0;
                sign_ring[wr_pos] = smp[SAMPLE_BITS-1];
                wr_pos = (wr_pos + 1) % w;
                if (fill < w) fill++;
                if (fill >= ms) begin
                    start = (wr_pos + w - fill) % w;
                    crossings = 0;
                    for (i = 0; i + 1 < fill; i++) begin
                        if (sign_ring[(start + i) % w] != sign_ring[(start + i + 1) % w])
                            crossings++;
                    end
                    q = (crossings << 16) / (fill - 1);
                    r.rate  = q[RATE_W-1:0];
                    r.ready = 1'b1;
                    hi = q > hi_th;
                    lo = q < lo_th;
                    if (hi && !above_hi) begin
                        r.hi_ev  = 1'b1;
                        hi_total = bump(hi_total);
                    end
                    if (lo && !below_lo) begin
                        r.lo_ev  = 1'b1;
                        lo_total = bump(lo_total);
                    end
                    above_hi = hi;
                    below_lo = lo;
                end
                rec_total = bump(rec_total);
            end
            r.hi_cnt  = hi_total;
            r.lo_cnt  = lo_total;
            r.rec_cnt = rec_total;
            ready_beats += r.ready;
            hi_events   += r.hi_ev;
            lo_events   += r.lo_ev;
            pending_rates.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want,
                         got);
            end
        endfunction

        function void check_result_beat(logic [OUT_DATA_W-1:0] d);
            rate_beat_t e;
            checked++;
            if (pending_rates.size() == 0) begin
                errors++;
                $display("%0t: unexpected output beat, expected none, actual %0h", $realtime, d);
                return;
            end
            e = pending_rates.pop_front();
            compare_field("rate", 32'(e.rate), 32'(d[RATE_W-1:0]));
            compare_field("rate_ready", 32'(e.ready), 32'(d[READY_BIT]));
            compare_field("hi_flag", 32'(e.hi_ev), 32'(d[HEV_BIT]));
            compare_field("lo_flag", 32'(e.lo_ev), 32'(d[LEV_BIT]));
            compare_field("hi_count", e.hi_cnt, d[HCNT_LSB +: CNT_W]);
            compare_field("lo_count", e.lo_cnt, d[LCNT_LSB +: CNT_W]);
            compare_field("record_count", e.rec_cnt, d[RCNT_LSB +: CNT_W]);
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_addr;
    logic [CFG_W-1:0]       cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;

    crossing_rate_scoreboard sb = new();

    int unsigned beats_sent;
    int unsigned beats_left;
    int unsigned settings_used;
    int unsigned stall_cycles;
    bit          hold_done;

    windowed_zero_crossing_rate_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial aclk = 1'b0;
    always #HALF_PERIOD aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result_beat(m_tdata);
            if (s_tvalid && s_tready) sb.record_beat(s_tuser, s_tdata);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("windowed_zero_crossing_rate_top verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // receiver: random stalls, one long hold-off, one stretch with no stalls
    initial begin
        m_tready <= 1'b0;
        hold_done = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!hold_done && sb.checked >= HOLD_AT) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (sb.checked >= 550 && sb.checked < 650)
                    m_tready <= 1'b1;
                else
                    m_tready <= ($urandom_range(99) >= 34);
                @(posedge aclk);
            end
        end
    end

    task automatic send_beat(input logic cmd, input logic [IN_DATA_W-1:0] smp);
        if (beats_sent < 400 || beats_sent >= 500) begin
            while ($urandom_range(99) < 34) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_registers(input logic [CFG_W-1:0] win, input logic [CFG_W-1:0] mins,
                                   input logic [CFG_W-1:0] hi, input logic [CFG_W-1:0] lo);
        logic [CFG_W-1:0] vals [4];
        logic [CFG_IDX_W-1:0] idx [4];
        vals = '{win, mins, hi, lo};
        idx  = '{CFG_WINDOW_LENGTH, CFG_MIN_SAMPLES, CFG_HIGH_THRESHOLD, CFG_LOW_THRESHOLD};
        drain();
        for (int k = 0; k < 4; k++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= idx[k];
            cfg_data  <= vals[k];
            sb.write_register(idx[k], vals[k]);
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // one run of signs with a chosen pattern and random magnitudes
    task automatic send_sign_run();
        int unsigned          mode;
        int unsigned          len;
        logic                 neg;
        logic                 cmd;
        logic [IN_DATA_W-1:0] smp;
        mode = $urandom_range(9);
        len  = $urandom_range(1, 40);
        neg  = 1'($urandom_range(1));
        for (int k = 0; k < len && beats_left > 0; k++) begin
            case (mode)
                3, 4, 5: neg = ~neg;
                6, 7:    if ($urandom_range(7) == 0) neg = ~neg;
                8:       neg = 1'($urandom_range(1));
                default: ;
            endcase
            smp = {neg, 15'($urandom)};
            case ($urandom_range(15))
                0: smp = neg ? 16'hFFFF : 16'h0000;
                1: smp = neg ? 16'h8000 : 16'h7FFF;
                default: ;
            endcase
            cmd = CMD_RECORD;
            if (mode == 9) begin
                smp = 16'($urandom);
                if ($urandom_range(19) == 0) cmd = CMD_CLEAR;
            end else if ($urandom_range(199) == 0) begin
                cmd = CMD_CLEAR;
            end
            send_beat(cmd, smp);
            beats_left--;
        end
    endtask

    task automatic run_setting(input int unsigned win, input int unsigned mins,
                               input int unsigned hi, input int unsigned lo,
                               input int unsigned n);
        write_registers(CFG_W'(win), CFG_W'(mins), CFG_W'(hi), CFG_W'(lo));
        beats_left = n;
        while (beats_left > 0) send_sign_run();
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= CFG_WINDOW_LENGTH;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= CMD_RECORD;
        beats_sent    = 0;
        settings_used = 1;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: zero as positive, sign extremes, both event kinds, clear
        send_beat(CMD_RECORD, 16'h0000);
        send_beat(CMD_RECORD, 16'hFFFF);
        send_beat(CMD_RECORD, 16'h7FFF);
        send_beat(CMD_RECORD, 16'h8000);
        send_beat(CMD_RECORD, 16'h0001);
        send_beat(CMD_CLEAR, 16'h8000);
        send_beat(CMD_RECORD, 16'h7FFF);
        send_beat(CMD_RECORD, 16'h0000);
        send_beat(CMD_RECORD, 16'h1234);
        send_beat(CMD_RECORD, 16'h0000);
        send_beat(CMD_RECORD, 16'hC000);
        send_beat(CMD_RECORD, 16'h4000);
        send_beat(CMD_RECORD, 16'hFFFE);
        send_beat(CMD_RECORD, 16'h0002);
        send_beat(CMD_CLEAR, 16'hFFFF);
        send_beat(CMD_RECORD, 16'hFFFF);
        send_beat(CMD_RECORD, 16'h8000);
        send_beat(CMD_CLEAR, 16'h0000);
        send_beat(CMD_RECORD, 16'h5555);
        send_beat(CMD_RECORD, 16'hAAAA);

        run_setting(2,   2,   32768,  6554,  100);
        run_setting(0,   0,   65536,  0,     60);
        run_setting(256, 256, 40000,  30000, 300);
        run_setting(16,  4,   20000,  10000, 60);
        run_setting(511, 1,   0,      65536, 60);
        run_setting(8,   20,  131071, 131071, 40);
        run_setting(1,   2,   30000,  30000, 60);
        run_setting(33,  33,  1000,   65000, 60);
        run_setting(300, 200, 16384,  8192,  60);
        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d output beats from %0d input beats over %0d register settings.",
                 sb.checked, beats_sent, settings_used);
        $display("Rate ready on %0d beats; %0d high and %0d low events predicted.",
                 sb.ready_beats, sb.hi_events, sb.lo_events);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("windowed_zero_crossing_rate_top verification clean");
        end else begin
            $display("windowed_zero_crossing_rate_top verification failed");
        end
        $finish;
    end

endmodule

/* windowed_zero_crossing_rate_top.f */
src/wzcr_pkg.sv
src/wzcr_hist.sv
src/wzcr_div.sv
src/windowed_zero_crossing_rate_top.sv
dv/testbench.sv
